@@ rtl/scr_pkg.sv @@
// Package for the spectrogram column renderer: sizes, codes, the queue command
// type and the warm colour ramp table. Used by every module of the block but scr_ram.
`default_nettype none

package scr_pkg;

  // Geometry of the panel strip and of the bin store.
  localparam int COLUMN_HEIGHT = 172;
  localparam int STRIP_WIDTH   = 256;
  localparam int MAX_BINS      = 256;

  // Derived widths.
  localparam int ROW_W    = (COLUMN_HEIGHT > 1) ? $clog2(COLUMN_HEIGHT) : 1;
  localparam int ADDR_W   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W    = $clog2(MAX_BINS + 1);
  localparam int SCROLL_W = $clog2(STRIP_WIDTH);

  // Field widths of the ports.
  localparam int OFFSET_W = 10;
  localparam int COLOR_W  = 16;
  localparam int COL_W    = 11;
  localparam int PROW_W   = 8;
  localparam int BIN_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_X_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_COLOR   = 1'd1;

  // Reset value of the cursor colour.
  localparam logic [COLOR_W-1:0] CURSOR_COLOR_RESET = 16'h3985;

  // Item operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // One pixel to be rendered, passed from the front to the back.
  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [PROW_W-1:0] row;
    logic [ADDR_W-1:0] addr;
    logic              cursor;
    logic              last;
  } scr_cmd_t;

  // Fill status of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Colour ramp stops: position and 8-bit red, green and blue.
  localparam int RAMP_POS [5] = '{0, 56, 128, 190, 255};
  localparam int RAMP_R   [5] = '{'h0B, 'h2E, 'h8A, 'hFF, 'hFF};
  localparam int RAMP_G   [5] = '{'h09, 'h18, 'h3F, 'hB0, 'hF2};
  localparam int RAMP_B   [5] = '{'h08, 'h0A, 'h0C, 'h20, 'hCC};
  localparam int RED_MASK   = 'hF8;
  localparam int GREEN_MASK = 'hFC;

  typedef logic [255:0][COLOR_W-1:0] ramp_lut_t;

  // Unsigned quotient by restoring long division; every numerator of the ramp
  // fits in 16 bits.
  function automatic int quotient(input int num, input int den);
    int q;
    int part;
    int k;
    q = 0;
    part = 0;
    for (k = 15; k >= 0; k--) begin
      part = (part << 1) | ((num >> k) & 1);
      q = q << 1;
      if (part >= den) begin
        part = part - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // Builds the amplitude to RGB565 table; evaluated once at elaboration.
  function automatic ramp_lut_t build_ramp_lut();
    ramp_lut_t lut;
    int v;
    int k;
    int seg;
    int span;
    int t;
    int r;
    int g;
    int b;
    for (v = 0; v < 256; v++) begin
      seg = 0;
      for (k = 0; k < 3; k++) begin
        if (seg == k && v > RAMP_POS[k+1]) seg = k + 1;
      end
      span = RAMP_POS[seg+1] - RAMP_POS[seg];
      t = (span != 0) ? quotient((v - RAMP_POS[seg]) * 255, span) : 0;
      r = (RAMP_R[seg] + quotient((RAMP_R[seg+1] - RAMP_R[seg]) * t, 255)) & 'hFF;
      g = (RAMP_G[seg] + quotient((RAMP_G[seg+1] - RAMP_G[seg]) * t, 255)) & 'hFF;
      b = (RAMP_B[seg] + quotient((RAMP_B[seg+1] - RAMP_B[seg]) * t, 255)) & 'hFF;
      lut[v] = COLOR_W'(((r & RED_MASK) << 8) | ((g & GREEN_MASK) << 3) | (b >> 3));
    end
    return lut;
  endfunction

  localparam ramp_lut_t RAMP_LUT = build_ramp_lut();

endpackage

`default_nettype wire

@@ rtl/spectrogram_column_renderer.sv @@
// Top level of the scrolling spectrogram column renderer.
// Depends on scr_pkg, scr_front, scr_queue, scr_back and scr_ram.
//
//   Channel   Handshake                Payload
//   input     in_valid / in_stall      op, bin_value, last_bin
//   output    out_valid / out_stall    pixel_column, pixel_row, pixel_color,
//                                      is_cursor, end_of_update
//   config    cfg_write                cfg_index, cfg_data
//
// One item is taken per clock while in_stall is low; ticks give one pixel per clock
// while out_stall allows, presented through queue write, bin store read, output register.
// The first load of a new column waits until the command queue has drained,
// so that every pending row has read the bin store.
// Reset is synchronous and clears all control state; the bin store is not cleared.
// A stalled output backs up into the two-entry queue, then stalls the input.
`default_nettype none

module spectrogram_column_renderer
  import scr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  op,
  input  wire logic [BIN_W-1:0]      bin_value,
  input  wire logic                  last_bin,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COL_W-1:0]           pixel_column,
  output logic [PROW_W-1:0]          pixel_row,
  output logic [COLOR_W-1:0]         pixel_color,
  output logic                       is_cursor,
  output logic                       end_of_update
);

  logic [OFFSET_W-1:0] strip_x_offset;
  logic [COLOR_W-1:0]  cursor_color;
  q_status_t           q_status;
  scr_cmd_t            push_cmd;
  scr_cmd_t            head_cmd;
  logic                push;
  logic                pop;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [BIN_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [BIN_W-1:0]    ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      strip_x_offset <= '0;
      cursor_color   <= CURSOR_COLOR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_STRIP_X_OFFSET: strip_x_offset <= cfg_data[OFFSET_W-1:0];
        CFG_CURSOR_COLOR:   cursor_color   <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  scr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .bin_value      (bin_value),
    .last_bin       (last_bin),
    .strip_x_offset (strip_x_offset),
    .q_status       (q_status),
    .push           (push),
    .cmd            (push_cmd),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata)
  );

  scr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  // Bin store of one spectrum column.
  scr_ram #(
    .WIDTH (BIN_W),
    .DEPTH (MAX_BINS)
  ) u_bin_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (pop),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  scr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_cmd      (head_cmd),
    .q_status      (q_status),
    .pop           (pop),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .cursor_color  (cursor_color),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_column  (pixel_column),
    .pixel_row     (pixel_row),
    .pixel_color   (pixel_color),
    .is_cursor     (is_cursor),
    .end_of_update (end_of_update)
  );

endmodule

`default_nettype wire

@@ rtl/scr_ram.sv @@
// Generic single write port, single read port RAM with a registered read.
// Stands alone; no package needed.
`default_nettype none

module scr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                 wr_data,
  input  wire logic                             rd_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/scr_front.sv @@
// Front part: accepts load and tick items, keeps the column state and turns
// each tick of a render into a pixel command. Depends on scr_pkg.
`default_nettype none

module scr_front
  import scr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  op,
  input  wire logic [BIN_W-1:0]      bin_value,
  input  wire logic                  last_bin,
  input  wire logic [OFFSET_W-1:0]   strip_x_offset,
  input  wire q_status_t             q_status,
  output logic                       push,
  output scr_cmd_t                   cmd,
  output logic                       ram_we,
  output logic [ADDR_W-1:0]          ram_waddr,
  output logic [BIN_W-1:0]           ram_wdata
);

  logic                busy;
  logic                cursor;
  logic [ROW_W-1:0]    row;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_q;
  logic [ROW_W-1:0]    count_r;
  logic [CNT_W-1:0]    bin_idx;
  logic [ROW_W-1:0]    rem;
  logic [SCROLL_W-1:0] scroll;
  logic [SCROLL_W-1:0] scroll_next;
  logic [ROW_W:0]      rem_sum;
  logic                rem_wrap;
  logic                row_last;
  logic                not_full;
  logic                accept;
  logic                do_load;
  logic                do_tick;

  // A new column may only be loaded once all row commands have read the store.
  assign in_stall = q_status.full || (!busy && !q_status.empty);
  assign accept   = in_valid && !in_stall;
  assign do_load  = accept && (op == OP_LOAD) && !busy;
  assign do_tick  = accept && (op == OP_TICK) && busy;
  assign push     = do_tick;

  assign not_full  = count != CNT_W'(MAX_BINS);
  assign ram_we    = do_load && not_full;
  assign ram_waddr = count[ADDR_W-1:0];
  assign ram_wdata = bin_value;

  // Row to bin mapping steps by count/height, carrying the remainder.
  assign rem_sum  = {1'b0, rem} + {1'b0, count_r};
  assign rem_wrap = rem_sum >= (ROW_W+1)'(COLUMN_HEIGHT);
  assign row_last = row == ROW_W'(COLUMN_HEIGHT - 1);

  assign scroll_next = (scroll == SCROLL_W'(STRIP_WIDTH - 1)) ? '0 : scroll + 1'b1;

  // Command for the pixel of the current tick.
  always_comb begin
    cmd.column = cursor ? COL_W'(strip_x_offset) + COL_W'(scroll_next)
                        : COL_W'(strip_x_offset) + COL_W'(scroll);
    cmd.row    = PROW_W'(row);
    cmd.addr   = bin_idx[ADDR_W-1:0];
    cmd.cursor = cursor;
    cmd.last   = cursor && row_last;
  end

  // Column state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      cursor  <= 1'b0;
      row     <= '0;
      count   <= '0;
      count_q <= '0;
      count_r <= '0;
      bin_idx <= '0;
      rem     <= '0;
      scroll  <= '0;
    end else if (do_load) begin
      if (not_full) begin
        count <= count + 1'b1;
        if (count_r == ROW_W'(COLUMN_HEIGHT - 1)) begin
          count_r <= '0;
          count_q <= count_q + 1'b1;
        end else begin
          count_r <= count_r + 1'b1;
        end
      end
      if (last_bin) begin
        busy    <= 1'b1;
        cursor  <= 1'b0;
        row     <= '0;
        bin_idx <= '0;
        rem     <= '0;
      end
    end else if (do_tick) begin
      if (!cursor) begin
        if (rem_wrap) begin
          rem     <= ROW_W'(rem_sum - (ROW_W+1)'(COLUMN_HEIGHT));
          bin_idx <= bin_idx + count_q + 1'b1;
        end else begin
          rem     <= ROW_W'(rem_sum);
          bin_idx <= bin_idx + count_q;
        end
        if (row_last) begin
          cursor <= 1'b1;
          row    <= '0;
        end else begin
          row <= row + 1'b1;
        end
      end else if (row_last) begin
        busy    <= 1'b0;
        cursor  <= 1'b0;
        row     <= '0;
        count   <= '0;
        count_q <= '0;
        count_r <= '0;
        scroll  <= scroll_next;
      end else begin
        row <= row + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/scr_queue.sv @@
// Short command queue that decouples the front from the back.
// Depends on scr_pkg for the command type and depth.
`default_nettype none

module scr_queue
  import scr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire scr_cmd_t  push_cmd,
  input  wire logic      pop,
  output scr_cmd_t       head_cmd,
  output q_status_t      status
);

  scr_cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QPTR_W:0]       fill;

  assign head_cmd     = entries[rd_ptr];
  assign status.full  = fill == (QPTR_W+1)'(QUEUE_DEPTH);
  assign status.empty = fill == '0;

  // Storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/scr_back.sv @@
// Back part: pops pixel commands, reads the bin store, maps the amplitude
// through the colour ramp and holds the result item. Depends on scr_pkg.
`default_nettype none

module scr_back
  import scr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire scr_cmd_t             head_cmd,
  input  wire q_status_t            q_status,
  output logic                      pop,
  output logic [ADDR_W-1:0]         ram_raddr,
  input  wire logic [BIN_W-1:0]     ram_rdata,
  input  wire logic [COLOR_W-1:0]   cursor_color,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [COL_W-1:0]          pixel_column,
  output logic [PROW_W-1:0]         pixel_row,
  output logic [COLOR_W-1:0]        pixel_color,
  output logic                      is_cursor,
  output logic                      end_of_update
);

  logic     rd_valid;
  scr_cmd_t rd_cmd;
  logic     advance;

  // The read stage moves on when the output register is free or being taken.
  assign advance   = rd_valid && (!out_valid || !out_stall);
  assign pop       = !q_status.empty && (!rd_valid || advance);
  assign ram_raddr = head_cmd.addr;

  // Read stage: the store read is in flight alongside its command.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (pop) begin
      rd_valid <= 1'b1;
    end else if (advance) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) rd_cmd <= head_cmd;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_column  <= rd_cmd.column;
      pixel_row     <= rd_cmd.row;
      pixel_color   <= rd_cmd.cursor ? cursor_color : RAMP_LUT[ram_rdata];
      is_cursor     <= rd_cmd.cursor;
      end_of_update <= rd_cmd.last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/scr_checker.sv @@
// Port-level checks for the spectrogram column renderer, bound to the top level.
// Depends on scr_pkg.
`default_nettype none

module scr_checker
  import scr_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [COL_W-1:0]   pixel_column,
  input wire logic [PROW_W-1:0]  pixel_row,
  input wire logic [COLOR_W-1:0] pixel_color,
  input wire logic               is_cursor,
  input wire logic               end_of_update
);

  // A held item keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_column) &&
      $stable(pixel_row) && $stable(pixel_color) && $stable(is_cursor) &&
      $stable(end_of_update))
    else $error("held pixel item changed");

  // Only the cursor pass closes an update.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_update |-> is_cursor)
    else $error("end of update on a non-cursor pixel");

  // The update closes on the last row of the cursor pass.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_update |-> pixel_row == PROW_W'(COLUMN_HEIGHT - 1))
    else $error("end of update on the wrong row");

  // No result straight after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item after reset");

endmodule

bind spectrogram_column_renderer scr_checker u_scr_checker (.*);

`default_nettype wire

@@ bench/pixel_stream_checker.sv @@
`timescale 1ns / 100ps
// Pixel stream checker for the spectrogram column renderer: watches the input, output
// and register channels, predicts each pixel and compares. Depends on scr_pkg.

module pixel_stream_checker
  import scr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  op,
  input  logic [BIN_W-1:0]      bin_value,
  input  logic                  last_bin,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [COL_W-1:0]      pixel_column,
  input  logic [PROW_W-1:0]     pixel_row,
  input  logic [COLOR_W-1:0]    pixel_color,
  input  logic                  is_cursor,
  input  logic                  end_of_update,
  output int                    pixels_owed,
  output logic                  column_rendering,
  output int                    fail_count
);

  // Warm ramp stops, lowest first: {position, red, green, blue}.
  localparam logic [4:0][31:0] WARM_STOPS = {
    32'hFF_FF_F2_CC, 32'hBE_FF_B0_20, 32'h80_8A_3F_0C, 32'h38_2E_18_0A, 32'h00_0B_09_08
  };

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [PROW_W-1:0]  row;
    logic [COLOR_W-1:0] colour;
    logic               cursor;
    logic               last;
  } pixel_t;

  pixel_t           owed_pixels [$];
  logic [BIN_W-1:0] bin_mem [MAX_BINS];
  int unsigned      bins_loaded;
  int unsigned      scroll;
  int unsigned      emit_row;
  logic             rendering;
  logic [9:0]       x_offset;
  logic [COLOR_W-1:0] cursor_rgb;
  int               mismatches = 0;

  assign fail_count = mismatches;

  // Straight-line blend of one colour channel between two stops.
  function automatic int unsigned blend(input int unsigned lo_level,
                                        input int unsigned hi_level,
                                        input int unsigned frac);
    return lo_level + ((hi_level - lo_level) * frac) / 255;
  endfunction

  // Amplitude to RGB565 through the warm ramp, truncating at every step.
  function automatic logic [COLOR_W-1:0] warm_rgb565(input logic [BIN_W-1:0] amp);
    int unsigned seg;
    int unsigned frac;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    seg = 0;
    while (seg < 3 && amp > WARM_STOPS[seg+1][31:24]) seg++;
    lo = WARM_STOPS[seg];
    hi = WARM_STOPS[seg+1];
    frac = ((amp - lo[31:24]) * 255) / (hi[31:24] - lo[31:24]);
    red = blend(lo[23:16], hi[23:16], frac);
    green = blend(lo[15:8], hi[15:8], frac);
    blue = blend(lo[7:0], hi[7:0], frac);
    return {red[7:3], green[7:2], blue[7:3]};
  endfunction

  // Updates the column state for one accepted item and queues the pixel it causes.
  task automatic predict_pixel(input logic item_op, input logic [BIN_W-1:0] amp,
                               input logic item_last);
    pixel_t px;
    if (item_op == OP_LOAD) begin
      // Loads are ignored while a render runs; a full store drops the value.
      if (!rendering) begin
        if (bins_loaded < MAX_BINS) begin
          bin_mem[bins_loaded] = amp;
          bins_loaded++;
        end
        if (item_last) begin
          rendering = 1'b1;
          emit_row = 0;
        end
      end
    end else if (rendering) begin
      px.cursor = (emit_row >= COLUMN_HEIGHT);
      if (!px.cursor) begin
        px.column = COL_W'(x_offset + scroll);
        px.row = PROW_W'(emit_row);
        px.colour = warm_rgb565(bin_mem[(emit_row * bins_loaded) / COLUMN_HEIGHT]);
      end else begin
        px.column = COL_W'(x_offset + ((scroll + 1) % STRIP_WIDTH));
        px.row = PROW_W'(emit_row - COLUMN_HEIGHT);
        px.colour = cursor_rgb;
      end
      px.last = px.cursor && (emit_row == 2 * COLUMN_HEIGHT - 1);
      owed_pixels.push_back(px);
      // The last cursor pixel closes the column and moves the scroll on.
      if (px.last) begin
        scroll = (scroll + 1) % STRIP_WIDTH;
        rendering = 1'b0;
        bins_loaded = 0;
        emit_row = 0;
      end else begin
        emit_row++;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Results are checked before the item of the same edge is predicted, since a
  // result never leaves in the cycle its item went in.
  always @(posedge clk) begin : watch
    pixel_t want;
    if (rst) begin
      owed_pixels.delete();
      bins_loaded = 0;
      scroll = 0;
      emit_row = 0;
      rendering = 1'b0;
      x_offset = '0;
      cursor_rgb = CURSOR_COLOR_RESET;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_STRIP_X_OFFSET) x_offset = cfg_data[9:0];
        else if (cfg_index == CFG_CURSOR_COLOR) cursor_rgb = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (owed_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, got column %0d row %0d colour %h",
                   $time, pixel_column, pixel_row, pixel_color);
          mismatches++;
        end else begin
          want = owed_pixels.pop_front();
          compare_field("pixel_column", want.column, pixel_column);
          compare_field("pixel_row", want.row, pixel_row);
          compare_field("pixel_color", want.colour, pixel_color);
          compare_field("is_cursor", want.cursor, is_cursor);
          compare_field("end_of_update", want.last, end_of_update);
        end
      end
      if (in_valid && !in_stall) predict_pixel(op, bin_value, last_bin);
    end
    pixels_owed <= owed_pixels.size();
    column_rendering <= rendering;
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Bench top for the spectrogram column renderer: clock, reset, item and register
// stimulus and the verdict. Depends on scr_pkg, the block and pixel_stream_checker.

module tb;
  import scr_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 800;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_STRIP_X_OFFSET;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  op = OP_LOAD;
  logic [BIN_W-1:0]      bin_value = '0;
  logic                  last_bin = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COL_W-1:0]      pixel_column;
  logic [PROW_W-1:0]     pixel_row;
  logic [COLOR_W-1:0]    pixel_color;
  logic                  is_cursor;
  logic                  end_of_update;

  int                    pixels_owed;
  logic                  column_rendering;
  int                    fail_count;

  int                    burst_left = 0;
  int                    items_sent = 0;
  int                    cycle_count = 0;
  logic [BIN_W-1:0]      column_amps [$];

  spectrogram_column_renderer u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .bin_value     (bin_value),
    .last_bin      (last_bin),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_column  (pixel_column),
    .pixel_row     (pixel_row),
    .pixel_color   (pixel_color),
    .is_cursor     (is_cursor),
    .end_of_update (end_of_update)
  );

  pixel_stream_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .bin_value        (bin_value),
    .last_bin         (last_bin),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pixel_column     (pixel_column),
    .pixel_row        (pixel_row),
    .pixel_color      (pixel_color),
    .is_cursor        (is_cursor),
    .end_of_update    (end_of_update),
    .pixels_owed      (pixels_owed),
    .column_rendering (column_rendering),
    .fail_count       (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("spectrogram_column_renderer test failed");
      $finish;
    end
  end

  // Amplitudes lean towards the ramp stops and their neighbours.
  function automatic logic [BIN_W-1:0] pick_amplitude();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd55 + BIN_W'($urandom_range(0, 2));
      3: return 8'd127 + BIN_W'($urandom_range(0, 2));
      4: return 8'd189 + BIN_W'($urandom_range(0, 2));
      default: return BIN_W'($urandom);
    endcase
  endfunction

  // Offers one item, in bursts of random length with random gaps between them.
  task automatic send(input logic item_op, input logic [BIN_W-1:0] amp,
                      input logic item_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 400)
                                               : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    op <= item_op;
    bin_value <= amp;
    last_bin <= item_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Loads the bins of column_amps, the last one flagged, with stray idle ticks.
  task automatic send_bins(input int noise_pct);
    int k;
    for (k = 0; k < column_amps.size(); k++) begin
      if ($urandom_range(1, 100) <= noise_pct)
        send(OP_TICK, BIN_W'($urandom), 1'($urandom));
      send(OP_LOAD, column_amps[k], k == column_amps.size() - 1);
    end
    items_sent += column_amps.size();
  endtask

  // Ticks with stray loads, which the block ignores while it renders.
  task automatic send_ticks(input int count, input int noise_pct);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(1, 100) <= noise_pct)
        send(OP_LOAD, BIN_W'($urandom), 1'($urandom));
      send(OP_TICK, BIN_W'($urandom), 1'($urandom));
    end
    items_sent += count;
  endtask

  // Ticks out any render left, then waits until every pixel has come and the
  // block has had time to go quiet.
  task automatic finish_phase();
    while (column_rendering) send(OP_TICK, BIN_W'($urandom), 1'($urandom));
    in_valid <= 1'b0;
    @(posedge clk);
    while (column_rendering || pixels_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; unused data bits carry junk.
  task automatic set_registers(input logic [9:0] offset, input logic [COLOR_W-1:0] colour);
    cfg_write <= 1'b1;
    cfg_index <= CFG_STRIP_X_OFFSET;
    cfg_data <= {6'($urandom), offset};
    @(posedge clk);
    cfg_index <= CFG_CURSOR_COLOR;
    cfg_data <= colour;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Receiver: stall patterns that change now and then, and two long hold-offs
  // in the middle of a render so that the block backs up into its input.
  initial begin : receiver
    int stall_pct;
    int mode_left;
    int taken;
    int holds_done;
    stall_pct = 0;
    mode_left = 0;
    taken = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      if (holds_done < 2 && column_rendering && taken >= (holds_done == 0 ? 100 : 1100)) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 20;
            3: stall_pct = 50;
            default: stall_pct = 85;
          endcase
          mode_left = $urandom_range(16, 256);
        end
        mode_left--;
        out_stall <= ($urandom_range(1, 100) <= stall_pct);
      end
    end
  end

  // Sender: directed columns, then random columns, then the verdict.
  initial begin : sender
    logic [9:0]         offset;
    logic [COLOR_W-1:0] colour;
    int                 nbins;
    bit                 first_column;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Ticks while idle give nothing.
    send(OP_TICK, 8'h00, 1'b0);
    send(OP_TICK, 8'hFF, 1'b1);

    // Reset registers: ramp stops and their neighbours, a load with its last
    // flag in the middle of the render, and an idle tick after it.
    column_amps = '{8'd0, 8'd56, 8'd128, 8'd190, 8'd255, 8'd1, 8'd55, 8'd57,
                    8'd127, 8'd129, 8'd189, 8'd191, 8'd254, 8'hAA};
    send_bins(0);
    send_ticks(5, 0);
    send(OP_LOAD, 8'h77, 1'b1);
    send(OP_LOAD, 8'h00, 1'b0);
    send_ticks(2 * COLUMN_HEIGHT - 5, 0);
    send(OP_TICK, 8'h55, 1'b0);
    finish_phase();

    // Highest offset and white cursor on a column of one bin.
    set_registers(10'd1023, 16'hFFFF);
    column_amps = '{8'd255};
    send_bins(0);
    send_ticks(2 * COLUMN_HEIGHT, 0);
    finish_phase();

    // Lowest offset and black cursor on a column of two bins.
    set_registers(10'd0, 16'h0000);
    column_amps = '{8'd0, 8'd255};
    send_bins(0);
    send_ticks(2 * COLUMN_HEIGHT, 0);
    finish_phase();

    // Random columns, one per register setting; the first overfills the store.
    items_sent = 0;
    first_column = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: offset = 10'd0;
        1: offset = 10'd1023;
        default: offset = 10'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: colour = 16'h0000;
        1: colour = 16'hFFFF;
        default: colour = 16'($urandom);
      endcase
      set_registers(offset, colour);
      if (first_column) nbins = $urandom_range(MAX_BINS + 1, MAX_BINS + 8);
      else if ($urandom_range(0, 9) < 7) nbins = $urandom_range(1, 24);
      else if ($urandom_range(0, 2) == 0) nbins = MAX_BINS;
      else nbins = $urandom_range(25, MAX_BINS - 1);
      first_column = 1'b0;
      column_amps.delete();
      repeat (nbins) column_amps.push_back(pick_amplitude());
      send_bins(10);
      send_ticks(2 * COLUMN_HEIGHT, 5);
      finish_phase();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("spectrogram_column_renderer test passed");
    end else begin
      $display("spectrogram_column_renderer test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/scr_pkg.sv
rtl/scr_ram.sv
rtl/scr_front.sv
rtl/scr_queue.sv
rtl/scr_back.sv
rtl/spectrogram_column_renderer.sv
rtl/scr_checker.sv
bench/pixel_stream_checker.sv
bench/tb.sv
